// ===== hdl/rolling_spearman_rank_correlation_core_macros.svh =====
// Assertion macros shared by the rank correlation core.
`ifndef ROLLING_SPEARMAN_RANK_CORRELATION_CORE_MACROS_SVH
`define ROLLING_SPEARMAN_RANK_CORRELATION_CORE_MACROS_SVH

// Condition must hold at every edge out of reset.
`define RSRC_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Trigger at one edge implies condition at the next.
`define RSRC_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ===== hdl/rsrc_pkg.sv =====
// Types and constants of the rank correlation core.
`default_nettype none
package rsrc_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd20;
    localparam int MIN_WINDOW = 10;
    localparam logic signed [32:0] Q30_ONE = 33'sh0_4000_0000;
    localparam logic [32:0] Q31_ONE = 33'h0_8000_0000;

    typedef struct packed {
        logic signed [31:0] factor_sample;
        logic signed [31:0] return_sample;
        logic               series_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] ic_value;
        logic               window_full;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic setup_k;
        logic mul_sq;
        logic mul_den;
        logic latch_k;
        logic issue_i;
        logic diff;
        logic square;
        logic prep_div;
        logic div_step;
        logic out_zero;
        logic out_ic;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic i_last;
        logic k_last;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/rolling_spearman_rank_correlation_core.sv =====
// Rolling Spearman rank correlation core: top level.
// Input channel (i_in_valid/o_in_ready) takes one factor/return pair per item;
// series_start empties the window before the pair is stored.
// Output channel (o_out_valid/i_out_ready) returns one item per input item:
// ic_value in signed Q1.30 and window_full; ic_value is zero until n pairs
// are held. n is the cfg register (i_cfg_valid, always ready), clamped to
// [10, WINDOW_MAX]; write it only while the core is idle.
// An item with a partial window goes from S_CHECK to S_OUT_ZERO. A full
// window forms n*n and the denominator, then ranks each of its n samples
// through the single read port of the sample memory (one compare pair
// per cycle, n per rank), and a one-bit-per-cycle restoring divider takes
// a NUM_W-bit numerator (NUM_W = 3*clog2(WMAX+1)+33, 54 at WINDOW_MAX 64).
// One item is in flight at a time; a finished item waits in the output
// register, and the core accepts the next input while it waits, but does
// not finish that one until the slot is taken.
// Reset clears the fill count, write position and output valid, and sets
// the window length to 20. No memory clearing pass is run.
`default_nettype none
`include "rolling_spearman_rank_correlation_core_macros.svh"
module rolling_spearman_rank_correlation_core #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [rsrc_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire rsrc_pkg::t_in_item         i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rsrc_pkg::t_out_item             o_out_item
);
    import rsrc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    rsrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rsrc_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

    `RSRC_CHECK_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "second item taken")
    `RSRC_CHECK(a_zero_when_partial, !o_out_valid || o_out_item.window_full || o_out_item.ic_value == 32'sd0, "nonzero partial result")
    `RSRC_CHECK(a_rho_range, !o_out_valid || (o_out_item.ic_value <= 32'sh4000_0000 && o_out_item.ic_value >= -32'sh4000_0000), "rho out of range")

endmodule
`default_nettype wire

// ===== hdl/rsrc_ctrl.sv =====
// Sequencer for the rank correlation core.
`default_nettype none
module rsrc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire rsrc_pkg::t_status i_status,
    output rsrc_pkg::t_cmd        o_cmd
);
    import rsrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_KRD, S_KLAT, S_ISSUE, S_DRAIN,
        S_DIFF, S_SQ, S_PREP, S_DIV, S_OUT_ZERO, S_OUT_IC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.setup_k = 1'b1;
                n_state = i_status.full ? S_MUL1 : S_OUT_ZERO;
            end
            S_MUL1: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_den = 1'b1;
                n_state       = S_KRD;
            end
            S_KRD:  n_state = S_KLAT;
            S_KLAT: begin
                o_cmd.latch_k = 1'b1;
                n_state       = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue_i = 1'b1;
                if (i_status.i_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = i_status.k_last ? S_PREP : S_KRD;
            end
            S_PREP: begin
                o_cmd.prep_div = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_OUT_IC;
            end
            S_OUT_ZERO: begin
                if (slot_free) begin
                    o_cmd.out_zero = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_OUT_IC: begin
                if (slot_free) begin
                    o_cmd.out_ic = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rsrc_dp.sv =====
// Window storage, rank counters, rho arithmetic and divider.
`default_nettype none
module rsrc_dp #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic [rsrc_pkg::CFG_W-1:0] i_cfg_data,
    input  wire rsrc_pkg::t_in_item      i_in_item,
    input  wire rsrc_pkg::t_cmd          i_cmd,
    output rsrc_pkg::t_status            o_status,
    output rsrc_pkg::t_out_item          o_out_item
);
    import rsrc_pkg::*;

    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int RW    = CW + 1;
    localparam int DEN_W = 3 * CW + 1;
    localparam int NUM_W = DEN_W + 32;
    localparam int REM_W = DEN_W + 1;
    localparam int DCW   = $clog2(NUM_W + 1);
    localparam int XW    = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);
    localparam logic [AW-1:0] ALAST = AW'(WINDOW_MAX - 1);

    logic [SAMPLE_BITS-1:0] r_fmem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_rmem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_rd_f, r_rd_r, r_key_f, r_key_r;
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    r_fill, r_n, r_k, r_i;
    logic [CW-1:0]    r_less_f, r_eq_f, r_less_r, r_eq_r;
    logic [AW-1:0]    r_wp, r_last, r_ptr_k, r_ptr_i;
    logic [2*CW-1:0]  r_nsq;
    logic [DEN_W-1:0] r_den, r_dsum;
    logic [RW-1:0]    r_d;
    logic [NUM_W-1:0] r_num;
    logic [REM_W-1:0] r_rem;
    logic [31:0]      r_quo;
    logic [DCW-1:0]   r_dcnt;
    logic             r_cmp_en;
    t_out_item        r_out;

    logic [AW-1:0]    pos, rd_addr, ptr_k_dn, ptr_i_dn;
    logic [CW-1:0]    fill_base, n_clamp;
    logic [XW-1:0]    cfg_x;
    logic signed [SAMPLE_BITS-1:0] ext_f, ext_r;
    logic [SAMPLE_BITS-1:0] key_f, key_r;
    logic [RW-1:0]    rank_f, rank_r, diff_d;
    logic [2*RW-1:0]  sq;
    logic [DEN_W-1:0] den_prod;
    logic [DEN_W+1:0] three_d;
    logic [REM_W-1:0] rem_sh;
    logic             ge;
    logic [32:0]      q_sat;
    logic signed [32:0] ic_full;

    assign pos       = i_in_item.series_start ? '0 : r_wp;
    assign fill_base = i_in_item.series_start ? '0 : r_fill;
    assign cfg_x     = XW'(r_cfg);
    assign n_clamp   = (cfg_x < XW'(MIN_WINDOW)) ? CW'(MIN_WINDOW) :
                       (cfg_x > XW'(WINDOW_MAX)) ? WMAX : CW'(cfg_x);

    // Flip the sign bit so an unsigned compare gives signed order.
    assign ext_f = SAMPLE_BITS'(i_in_item.factor_sample);
    assign ext_r = SAMPLE_BITS'(i_in_item.return_sample);
    assign key_f = {~ext_f[SAMPLE_BITS-1], ext_f[SAMPLE_BITS-2:0]};
    assign key_r = {~ext_r[SAMPLE_BITS-1], ext_r[SAMPLE_BITS-2:0]};

    assign rd_addr  = i_cmd.issue_i ? r_ptr_i : r_ptr_k;
    assign ptr_k_dn = (r_ptr_k == '0) ? ALAST : r_ptr_k - 1'b1;
    assign ptr_i_dn = (r_ptr_i == '0) ? ALAST : r_ptr_i - 1'b1;

    // Doubled average rank: 2*less + equal + 1.
    assign rank_f   = {r_less_f, 1'b0} + RW'(r_eq_f) + RW'(1);
    assign rank_r   = {r_less_r, 1'b0} + RW'(r_eq_r) + RW'(1);
    assign diff_d   = (rank_f > rank_r) ? rank_f - rank_r : rank_r - rank_f;
    assign sq       = (2*RW)'(r_d) * (2*RW)'(r_d);
    assign den_prod = DEN_W'(r_n) * DEN_W'(r_nsq - (2*CW)'(1));
    assign three_d  = {1'b0, r_dsum, 1'b0} + (DEN_W+2)'(r_dsum);

    assign rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    assign q_sat   = ({1'b0, r_quo} > Q31_ONE) ? Q31_ONE : {1'b0, r_quo};
    assign ic_full = Q30_ONE - $signed(q_sat);

    assign o_status.full     = r_fill >= r_n;
    assign o_status.i_last   = r_i == r_n - 1'b1;
    assign o_status.k_last   = r_k == r_n - 1'b1;
    assign o_status.div_last = r_dcnt == DCW'(1);
    assign o_out_item        = r_out;

    always_ff @(posedge i_clk) begin
        r_rd_f <= r_fmem[rd_addr];
        r_rd_r <= r_rmem[rd_addr];
        if (i_cmd.accept) begin
            r_fmem[pos] <= key_f;
            r_rmem[pos] <= key_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_fill   <= '0;
            r_wp     <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            r_cmp_en <= i_cmd.issue_i;
            if (i_cmd.accept) begin
                r_wp   <= (pos == ALAST) ? '0 : pos + 1'b1;
                r_fill <= (fill_base == WMAX) ? WMAX : fill_base + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_last <= pos;
            r_n    <= n_clamp;
        end
        if (i_cmd.setup_k) begin
            r_ptr_k <= r_last;
            r_k     <= '0;
            r_dsum  <= '0;
        end
        if (i_cmd.mul_sq)  r_nsq <= (2*CW)'(r_n) * (2*CW)'(r_n);
        if (i_cmd.mul_den) r_den <= {den_prod[DEN_W-2:0], 1'b0};
        if (i_cmd.latch_k) begin
            r_key_f  <= r_rd_f;
            r_key_r  <= r_rd_r;
            r_ptr_i  <= r_last;
            r_i      <= '0;
            r_less_f <= '0;
            r_eq_f   <= '0;
            r_less_r <= '0;
            r_eq_r   <= '0;
        end
        if (i_cmd.issue_i) begin
            r_ptr_i <= ptr_i_dn;
            r_i     <= r_i + 1'b1;
        end
        // Compare the word read on the previous cycle.
        if (r_cmp_en) begin
            if (r_rd_f < r_key_f) r_less_f <= r_less_f + 1'b1;
            else if (r_rd_f == r_key_f) r_eq_f <= r_eq_f + 1'b1;
            if (r_rd_r < r_key_r) r_less_r <= r_less_r + 1'b1;
            else if (r_rd_r == r_key_r) r_eq_r <= r_eq_r + 1'b1;
        end
        if (i_cmd.diff) r_d <= diff_d;
        if (i_cmd.square) begin
            r_dsum  <= r_dsum + DEN_W'(sq);
            r_ptr_k <= ptr_k_dn;
            r_k     <= r_k + 1'b1;
        end
        if (i_cmd.prep_div) begin
            r_num  <= {three_d, 30'b0} + NUM_W'(r_den >> 1);
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= DCW'(NUM_W);
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quo  <= {r_quo[30:0], ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.out_zero) begin
            r_out.ic_value    <= '0;
            r_out.window_full <= 1'b0;
        end
        if (i_cmd.out_ic) begin
            r_out.ic_value    <= ic_full[31:0];
            r_out.window_full <= 1'b1;
        end
    end

endmodule
`default_nettype wire
